[rtl/i2cbs_pkg.sv]
// Types, codes and microprogram entry points shared by the I2C bit sequencer.
package i2cbs_pkg;

  localparam int unsigned PcW = 5;

  localparam logic [2:0] KindAcquire = 3'd0;
  localparam logic [2:0] KindStart   = 3'd1;
  localparam logic [2:0] KindStop    = 3'd2;
  localparam logic [2:0] KindWrite   = 3'd3;
  localparam logic [2:0] KindRead    = 3'd4;
  localparam logic [2:0] KindSample  = 3'd5;

  localparam logic [PcW-1:0] EntAcquire   = 5'd0;
  localparam logic [PcW-1:0] EntStart     = 5'd2;
  localparam logic [PcW-1:0] EntStop      = 5'd5;
  localparam logic [PcW-1:0] EntWrite     = 5'd8;
  localparam logic [PcW-1:0] EntRead      = 5'd14;
  localparam logic [PcW-1:0] EntAck       = 5'd16;
  localparam logic [PcW-1:0] EntBit       = 5'd17;
  localparam logic [PcW-1:0] EntMasterAck = 5'd20;
  localparam logic [PcW-1:0] PcLast       = 5'd22;

  localparam logic [3:0] BitsPerByte = 4'd8;
  localparam logic [3:0] LastBitIdx  = 4'd7;

  typedef enum logic [1:0] {
    PEND_IDLE,
    PEND_WACK,
    PEND_RBIT
  } pend_e;

  typedef enum logic [1:0] {
    LVL_LOW,
    LVL_HIGH,
    LVL_DATA
  } lvl_e;

  typedef enum logic [1:0] {
    OP_NEXT,
    OP_LOOP,
    OP_JFULL
  } seq_op_e;

  typedef enum logic {
    PIN_SCL,
    PIN_SDA
  } pin_e;

  typedef struct packed {
    pin_e           pin;
    lvl_e           lvl;
    logic           req;
    logic           done;
    logic           last;
    logic           rbyte;
    logic           ack;
    seq_op_e        op;
    logic [PcW-1:0] target;
    pend_e          pend;
  } ucode_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       bus_select;
    logic [7:0] write_byte;
    logic       sda_level;
  } in_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       pin_bus;
    logic       sample_request;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_bit;
    logic       last;
  } out_t;

  typedef struct packed {
    logic   step;
    ucode_t uc;
    logic   cmd_load;
    logic   wr_load;
    logic   rd_clear;
    logic   smp_shift;
    logic   ack_load;
    in_t    item;
  } dp_ctl_t;

  typedef struct packed {
    logic cnt_seven;
    logic cnt_full;
  } dp_stat_t;

endpackage

[rtl/i2cbs_ucode_rom.sv]
// Control store: one microcode word per pin phase step.
module i2cbs_ucode_rom (
  input  logic [i2cbs_pkg::PcW-1:0] addr_i,
  output i2cbs_pkg::ucode_t         uc_o
);

  function automatic i2cbs_pkg::ucode_t uw(
    i2cbs_pkg::pin_e              pin,
    i2cbs_pkg::lvl_e              lvl,
    logic                         req,
    logic                         done,
    logic                         last,
    logic                         rbyte,
    logic                         ack,
    i2cbs_pkg::seq_op_e           op,
    logic [i2cbs_pkg::PcW-1:0]    target,
    i2cbs_pkg::pend_e             pend
  );
    i2cbs_pkg::ucode_t w;
    w.pin    = pin;
    w.lvl    = lvl;
    w.req    = req;
    w.done   = done;
    w.last   = last;
    w.rbyte  = rbyte;
    w.ack    = ack;
    w.op     = op;
    w.target = target;
    w.pend   = pend;
    return w;
  endfunction

  always_comb begin
    case (addr_i)
      // acquire
      5'd0:  uc_o = uw(i2cbs_pkg::PIN_SCL, i2cbs_pkg::LVL_HIGH, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                       i2cbs_pkg::OP_NEXT, '0, i2cbs_pkg::PEND_IDLE);
      5'd1:  uc_o = uw(i2cbs_pkg::PIN_SDA, i2cbs_pkg::LVL_HIGH, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
                       i2cbs_pkg::OP_NEXT, '0, i2cbs_pkg::PEND_IDLE);
      // start
      5'd2:  uc_o = uw(i2cbs_pkg::PIN_SCL, i2cbs_pkg::LVL_HIGH, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                       i2cbs_pkg::OP_NEXT, '0, i2cbs_pkg::PEND_IDLE);
      5'd3:  uc_o = uw(i2cbs_pkg::PIN_SDA, i2cbs_pkg::LVL_LOW, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                       i2cbs_pkg::OP_NEXT, '0, i2cbs_pkg::PEND_IDLE);
      5'd4:  uc_o = uw(i2cbs_pkg::PIN_SCL, i2cbs_pkg::LVL_LOW, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
                       i2cbs_pkg::OP_NEXT, '0, i2cbs_pkg::PEND_IDLE);
      // stop
      5'd5:  uc_o = uw(i2cbs_pkg::PIN_SDA, i2cbs_pkg::LVL_LOW, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                       i2cbs_pkg::OP_NEXT, '0, i2cbs_pkg::PEND_IDLE);
      5'd6:  uc_o = uw(i2cbs_pkg::PIN_SCL, i2cbs_pkg::LVL_HIGH, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                       i2cbs_pkg::OP_NEXT, '0, i2cbs_pkg::PEND_IDLE);
      5'd7:  uc_o = uw(i2cbs_pkg::PIN_SDA, i2cbs_pkg::LVL_HIGH, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
                       i2cbs_pkg::OP_NEXT, '0, i2cbs_pkg::PEND_IDLE);
      // write byte, bit loop
      5'd8:  uc_o = uw(i2cbs_pkg::PIN_SDA, i2cbs_pkg::LVL_DATA, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                       i2cbs_pkg::OP_NEXT, '0, i2cbs_pkg::PEND_IDLE);
      5'd9:  uc_o = uw(i2cbs_pkg::PIN_SCL, i2cbs_pkg::LVL_HIGH, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                       i2cbs_pkg::OP_NEXT, '0, i2cbs_pkg::PEND_IDLE);
      5'd10: uc_o = uw(i2cbs_pkg::PIN_SCL, i2cbs_pkg::LVL_LOW, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                       i2cbs_pkg::OP_LOOP, i2cbs_pkg::EntWrite, i2cbs_pkg::PEND_IDLE);
      // write byte, release for ack
      5'd11: uc_o = uw(i2cbs_pkg::PIN_SDA, i2cbs_pkg::LVL_HIGH, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                       i2cbs_pkg::OP_NEXT, '0, i2cbs_pkg::PEND_IDLE);
      5'd12: uc_o = uw(i2cbs_pkg::PIN_SDA, i2cbs_pkg::LVL_HIGH, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                       i2cbs_pkg::OP_NEXT, '0, i2cbs_pkg::PEND_IDLE);
      5'd13: uc_o = uw(i2cbs_pkg::PIN_SCL, i2cbs_pkg::LVL_HIGH, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
                       i2cbs_pkg::OP_NEXT, '0, i2cbs_pkg::PEND_WACK);
      // read byte
      5'd14: uc_o = uw(i2cbs_pkg::PIN_SDA, i2cbs_pkg::LVL_HIGH, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                       i2cbs_pkg::OP_NEXT, '0, i2cbs_pkg::PEND_IDLE);
      5'd15: uc_o = uw(i2cbs_pkg::PIN_SCL, i2cbs_pkg::LVL_HIGH, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
                       i2cbs_pkg::OP_NEXT, '0, i2cbs_pkg::PEND_RBIT);
      // ack sample after write
      5'd16: uc_o = uw(i2cbs_pkg::PIN_SCL, i2cbs_pkg::LVL_LOW, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1,
                       i2cbs_pkg::OP_NEXT, '0, i2cbs_pkg::PEND_IDLE);
      // read bit sample
      5'd17: uc_o = uw(i2cbs_pkg::PIN_SCL, i2cbs_pkg::LVL_LOW, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                       i2cbs_pkg::OP_JFULL, i2cbs_pkg::EntMasterAck, i2cbs_pkg::PEND_IDLE);
      5'd18: uc_o = uw(i2cbs_pkg::PIN_SDA, i2cbs_pkg::LVL_HIGH, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                       i2cbs_pkg::OP_NEXT, '0, i2cbs_pkg::PEND_IDLE);
      5'd19: uc_o = uw(i2cbs_pkg::PIN_SCL, i2cbs_pkg::LVL_HIGH, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
                       i2cbs_pkg::OP_NEXT, '0, i2cbs_pkg::PEND_RBIT);
      // master ack after eighth bit
      5'd20: uc_o = uw(i2cbs_pkg::PIN_SDA, i2cbs_pkg::LVL_LOW, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                       i2cbs_pkg::OP_NEXT, '0, i2cbs_pkg::PEND_IDLE);
      5'd21: uc_o = uw(i2cbs_pkg::PIN_SCL, i2cbs_pkg::LVL_HIGH, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                       i2cbs_pkg::OP_NEXT, '0, i2cbs_pkg::PEND_IDLE);
      5'd22: uc_o = uw(i2cbs_pkg::PIN_SCL, i2cbs_pkg::LVL_LOW, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0,
                       i2cbs_pkg::OP_NEXT, '0, i2cbs_pkg::PEND_IDLE);
      default: uc_o = uw(i2cbs_pkg::PIN_SCL, i2cbs_pkg::LVL_LOW, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
                         i2cbs_pkg::OP_NEXT, '0, i2cbs_pkg::PEND_IDLE);
    endcase
  end

endmodule

[rtl/i2cbs_datapath.sv]
// Datapath: pin levels, shift register, bit counter, ack and bus registers.
module i2cbs_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  i2cbs_pkg::dp_ctl_t  ctl_i,
  output i2cbs_pkg::dp_stat_t stat_o,
  output i2cbs_pkg::out_t     res_o
);

  logic [3:0] pins_q, pins_d, pins_nx;
  logic [7:0] shift_q, shift_d;
  logic [3:0] cnt_q, cnt_d;
  logic       ack_q, ack_d;
  logic       bus_q, bus_d;
  logic [1:0] pidx;
  logic       lvl;

  always_comb begin
    pidx = {bus_q, ctl_i.uc.pin};
    case (ctl_i.uc.lvl)
      i2cbs_pkg::LVL_LOW:  lvl = 1'b0;
      i2cbs_pkg::LVL_HIGH: lvl = 1'b1;
      i2cbs_pkg::LVL_DATA: lvl = shift_q[7];
      default:             lvl = 1'b1;
    endcase
    pins_nx       = pins_q;
    pins_nx[pidx] = lvl;
    pins_d        = ctl_i.step ? pins_nx : pins_q;
  end

  always_comb begin
    shift_d = shift_q;
    cnt_d   = cnt_q;
    if (ctl_i.wr_load) begin
      shift_d = ctl_i.item.write_byte;
      cnt_d   = '0;
    end else if (ctl_i.rd_clear) begin
      shift_d = '0;
      cnt_d   = '0;
    end else if (ctl_i.smp_shift) begin
      shift_d = {shift_q[6:0], ctl_i.item.sda_level};
      cnt_d   = cnt_q + 4'd1;
    end else if (ctl_i.step && ctl_i.uc.op == i2cbs_pkg::OP_LOOP) begin
      shift_d = {shift_q[6:0], 1'b0};
      cnt_d   = cnt_q + 4'd1;
    end
    ack_d = ctl_i.ack_load ? ctl_i.item.sda_level : ack_q;
    bus_d = ctl_i.cmd_load ? ctl_i.item.bus_select : bus_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pins_q  <= 4'hF;
      shift_q <= '0;
      cnt_q   <= '0;
      ack_q   <= 1'b0;
      bus_q   <= 1'b0;
    end else begin
      pins_q  <= pins_d;
      shift_q <= shift_d;
      cnt_q   <= cnt_d;
      ack_q   <= ack_d;
      bus_q   <= bus_d;
    end
  end

  assign stat_o.cnt_seven = (cnt_q == i2cbs_pkg::LastBitIdx);
  assign stat_o.cnt_full  = (cnt_q == i2cbs_pkg::BitsPerByte);

  assign res_o.scl_release    = pins_nx[{bus_q, 1'b0}];
  assign res_o.sda_release    = pins_nx[{bus_q, 1'b1}];
  assign res_o.pin_bus        = bus_q;
  assign res_o.sample_request = ctl_i.uc.req;
  assign res_o.done_res       = ctl_i.uc.done;
  assign res_o.read_byte      = ctl_i.uc.rbyte ? shift_q : 8'd0;
  assign res_o.ack_bit        = ctl_i.uc.ack & ack_q;
  assign res_o.last           = ctl_i.uc.last;

endmodule

[rtl/i2c_master_bit_sequencer.sv]
// Top level: command dispatch, microcode sequencer and output register.
// Open-drain I2C master for two buses driven by a small microprogram. Each
// accepted command or sample word starts a microcode routine that steps one
// control word per clock while the output is not stalled and emits one pin
// phase word per step; the input stalls until the routine's final phase is
// issued. Routines exist for acquire, start, stop, write, read, ack sample
// and read bit sample, the last one adding the master ack after the eighth
// bit. Ignored words (unused kinds, samples while idle, commands while a
// sample is awaited) are accepted and give no output.
module i2c_master_bit_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  i2cbs_pkg::in_t   in_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output i2cbs_pkg::out_t  out_word_o
);

  logic [i2cbs_pkg::PcW-1:0] pc_q, pc_d, pc_inc;
  logic                      run_q, run_d;
  i2cbs_pkg::pend_e          pend_q, pend_d;
  logic                      ov_q, ov_d;
  i2cbs_pkg::out_t           od_q, od_d;

  i2cbs_pkg::ucode_t   uc;
  i2cbs_pkg::dp_ctl_t  ctl;
  i2cbs_pkg::dp_stat_t stat;
  i2cbs_pkg::out_t     res;

  logic acc, is_cmd, smp_ack, smp_bit, step_en;

  i2cbs_ucode_rom u_rom (
    .addr_i (pc_q),
    .uc_o   (uc)
  );

  i2cbs_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .stat_o (stat),
    .res_o  (res)
  );

  assign in_stall_o = run_q;
  assign acc        = in_valid_i && !run_q;
  assign is_cmd     = acc && (in_word_i.kind <= i2cbs_pkg::KindRead)
                      && (pend_q == i2cbs_pkg::PEND_IDLE);
  assign smp_ack    = acc && (in_word_i.kind == i2cbs_pkg::KindSample)
                      && (pend_q == i2cbs_pkg::PEND_WACK);
  assign smp_bit    = acc && (in_word_i.kind == i2cbs_pkg::KindSample)
                      && (pend_q == i2cbs_pkg::PEND_RBIT);
  assign step_en    = run_q && (!ov_q || !out_stall_i);
  assign pc_inc     = pc_q + 5'd1;

  always_comb begin
    ctl.step      = step_en;
    ctl.uc        = uc;
    ctl.cmd_load  = is_cmd;
    ctl.wr_load   = is_cmd && (in_word_i.kind == i2cbs_pkg::KindWrite);
    ctl.rd_clear  = is_cmd && (in_word_i.kind == i2cbs_pkg::KindRead);
    ctl.smp_shift = smp_bit;
    ctl.ack_load  = smp_ack;
    ctl.item      = in_word_i;
  end

  always_comb begin
    pc_d   = pc_q;
    run_d  = run_q;
    pend_d = pend_q;
    if (is_cmd) begin
      run_d = 1'b1;
      case (in_word_i.kind)
        i2cbs_pkg::KindAcquire: pc_d = i2cbs_pkg::EntAcquire;
        i2cbs_pkg::KindStart:   pc_d = i2cbs_pkg::EntStart;
        i2cbs_pkg::KindStop:    pc_d = i2cbs_pkg::EntStop;
        i2cbs_pkg::KindWrite:   pc_d = i2cbs_pkg::EntWrite;
        default:                pc_d = i2cbs_pkg::EntRead;
      endcase
    end else if (smp_ack) begin
      run_d = 1'b1;
      pc_d  = i2cbs_pkg::EntAck;
    end else if (smp_bit) begin
      run_d = 1'b1;
      pc_d  = i2cbs_pkg::EntBit;
    end else if (step_en) begin
      if (uc.last) begin
        run_d  = 1'b0;
        pend_d = uc.pend;
      end else begin
        case (uc.op)
          i2cbs_pkg::OP_LOOP:  pc_d = stat.cnt_seven ? pc_inc : uc.target;
          i2cbs_pkg::OP_JFULL: pc_d = stat.cnt_full ? uc.target : pc_inc;
          default:             pc_d = pc_inc;
        endcase
      end
    end
  end

  always_comb begin
    ov_d = ov_q;
    od_d = od_q;
    if (step_en) begin
      ov_d = 1'b1;
      od_d = res;
    end else if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      run_q  <= 1'b0;
      pend_q <= i2cbs_pkg::PEND_IDLE;
      ov_q   <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      run_q  <= run_d;
      pend_q <= pend_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_d;
  end

  assign out_valid_o = ov_q;
  assign out_word_o  = od_q;

  a_last_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en && uc.last) |=> !run_q)
    else $error("sequencer still running after final phase");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> (pc_q <= i2cbs_pkg::PcLast))
    else $error("microcode address out of program");

  a_req_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && od_q.sample_request) |-> od_q.last)
    else $error("sample request on a non-final phase word");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en && !uc.last) |=> run_q)
    else $error("routine ended before its final phase");

endmodule
